@@ rtl/sm3_pkg.sv @@
// SM3 package: initial value, round constants and the round helper functions.
// No dependencies; used by every module of the SM3 hash engine.
package sm3_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    localparam t_word IV0 = 32'h7380166f;
    localparam t_word IV1 = 32'h4914b2b9;
    localparam t_word IV2 = 32'h172442d7;
    localparam t_word IV3 = 32'hda8a0600;
    localparam t_word IV4 = 32'ha96f30bc;
    localparam t_word IV5 = 32'h163138aa;
    localparam t_word IV6 = 32'he38dee4d;
    localparam t_word IV7 = 32'hb0fb0e4e;
    localparam t_word TjLow  = 32'h79cc4519;
    localparam t_word TjHigh = 32'h7a879d8a;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [2*WordW-1:0] d;
        d = {x, x} << n;
        return d[2*WordW-1:WordW];
    endfunction

    function automatic t_word p0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word p1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic t_word iv_word(input logic [2:0] i);
        t_word v;
        case (i)
            3'd0: v = IV0;
            3'd1: v = IV1;
            3'd2: v = IV2;
            3'd3: v = IV3;
            3'd4: v = IV4;
            3'd5: v = IV5;
            3'd6: v = IV6;
            default: v = IV7;
        endcase
        return v;
    endfunction

    // Status from the compression core to the byte packer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

@@ rtl/sm3_if.sv @@
// Valid/ready stream interfaces for the SM3 hash engine.
// Depends on nothing.
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last;
    modport source (output valid, message_word, byte_count, last, input ready);
    modport sink   (input valid, message_word, byte_count, last, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sm3_core.sv @@
// SM3 compression core: one round per cycle over a 16-word sliding window.
// Depends on sm3_pkg.
module sm3_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_reload,
    input  sm3_pkg::t_word       i_block [16],
    output sm3_pkg::t_core_stat  o_stat,
    output sm3_pkg::t_word       o_cv [8]
);
    import sm3_pkg::*;

    t_word r_w [16];
    t_word r_v [8];
    t_word r_cv [8];
    logic [6:0] r_round;
    logic r_busy;
    logic r_done;

    logic  early;
    t_word a12, ss1, ss2, f1, g1, tt1, tt2, wnew, tj;

    // Sliding window holds W[j..j+15]; the next word W[j+16] comes from it.
    always_comb begin
        early = (r_round < 7'd16);
        tj    = early ? TjLow : TjHigh;
        a12   = rotl(r_v[0], 5'd12);
        ss1   = rotl(a12 + r_v[4] + rotl(tj, r_round[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        f1    = early ? (r_v[0] ^ r_v[1] ^ r_v[2])
                      : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
        g1    = early ? (r_v[4] ^ r_v[5] ^ r_v[6])
                      : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
        tt1   = f1 + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2   = g1 + r_v[7] + ss1 + r_w[0];
        wnew  = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int i = 0; i < 16; i++) r_w[i] <= i_block[i];
                for (int i = 0; i < 8; i++) r_v[i] <= r_cv[i];
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wnew;
                r_v[0] <= tt1;
                r_v[1] <= r_v[0];
                r_v[2] <= rotl(r_v[1], 5'd9);
                r_v[3] <= r_v[2];
                r_v[4] <= p0(tt2);
                r_v[5] <= r_v[4];
                r_v[6] <= rotl(r_v[5], 5'd19);
                r_v[7] <= r_v[6];
                if (r_round == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_round <= r_round + 7'd1;
            end else if (r_done) begin
                for (int i = 0; i < 8; i++) r_cv[i] <= r_cv[i] ^ r_v[i];
            end else if (i_reload) begin
                for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
            end
        end
    end

    assign o_stat.busy = r_busy | r_done;
    assign o_stat.done = r_done;
    always_comb for (int i = 0; i < 8; i++) o_cv[i] = r_cv[i];
endmodule

@@ rtl/sm3_hash_engine.sv @@
// SM3 hash engine top level: byte packer, padding sequencer and digest output.
// Depends on sm3_pkg, sm3_if and sm3_core.
//
//   channel  direction  payload                                   transfer when
//   s_in     sink       message_word[32], byte_count[3], last[1]  valid & ready
//   m_out    source     digest_word[32], word_index[3], last_word valid & ready
//
// Each input transfer is accepted in an idle cycle, then its valid bytes are packed
// into the block one by one. When byte 63 of the block has gone in, the shared
// round unit is launched, runs 64 rounds at one per cycle and then folds the
// result into the chaining value, and input is held off throughout. A last
// transfer adds the padding bytes, one or two such compressions and eight output
// transfers; each digest word holds under stall and input reopens the cycle
// after the eighth transfer.
// Reset (synchronous, active low) loads the initial value and clears counters.
module sm3_hash_engine (
    input logic i_clk,
    input logic i_rst_n,
    sm3_in_if.sink    s_in,
    sm3_out_if.source m_out
);
    import sm3_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StPack  = 3'd1;
    localparam logic [2:0] StPad   = 3'd2;
    localparam logic [2:0] StWait  = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;
    localparam logic [2:0] StStart = 3'd5;

    logic [2:0]  r_state, n_state;
    t_word       r_blk [16];
    logic [5:0]  r_fill;
    logic [60:0] r_len;
    logic [31:0] r_word;
    logic [2:0]  r_cnt;
    logic [1:0]  r_bi;
    logic        r_last;
    logic        r_padded;   // the 0x80 marker has been placed
    logic        r_lenok;    // the length field belongs in the current block
    logic        r_lenin;    // the final length byte has been placed
    logic        r_resume;   // the block filled before the current word was done
    logic [2:0]  r_oidx;
    logic        r_ovalid;

    logic        start, reload;
    logic        pack_end;
    t_core_stat  stat;
    t_word       cv [8];
    logic [63:0] bits;
    logic [7:0]  pbyte;
    logic [2:0]  cnt_sat;

    sm3_core u_core (
        .i_clk, .i_rst_n,
        .i_start(start), .i_reload(reload), .i_block(r_blk),
        .o_stat(stat), .o_cv(cv)
    );

    assign cnt_sat = (s_in.byte_count > 3'd4) ? 3'd4 : s_in.byte_count;
    assign bits    = {r_len, 3'b000};
    assign s_in.ready = (r_state == StIdle);
    assign reload  = (r_state == StOut) && m_out.ready && r_ovalid && (r_oidx == 3'd7);
    assign pack_end = (r_bi == r_cnt[1:0] - 2'd1) || (r_cnt == 3'd4 && r_bi == 2'd3);

    // The byte to write this cycle: message byte, padding marker, zero or length.
    // The length only goes in a block whose marker landed at byte 55 or earlier,
    // or in the fresh block that follows a marker block with no room left.
    always_comb begin
        if (r_state == StPack) begin
            pbyte = r_word[31:24];
        end else if (!r_padded) begin
            pbyte = PadByte;
        end else if (r_lenok && r_fill >= LenStart) begin
            pbyte = bits[8'(6'd63 - {r_fill[2:0], 3'b000}) -: 8];
        end else begin
            pbyte = 8'h00;
        end
    end

    // The core copies the block in the cycle after byte 63 has been written.
    assign start = (r_state == StStart);

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: if (s_in.valid) begin
                if (cnt_sat != 3'd0) n_state = StPack;
                else if (s_in.last) n_state = StPad;
            end
            StPack: begin
                if (r_fill == 6'd63) n_state = StStart;
                else if (pack_end) n_state = r_last ? StPad : StIdle;
            end
            StPad: if (r_fill == 6'd63) n_state = StStart;
            StStart: n_state = StWait;
            StWait: if (stat.done) begin
                if (r_resume) n_state = StPack;
                else if (!r_last) n_state = StIdle;
                else if (r_lenin) n_state = StOut;
                else n_state = StPad;
            end
            StOut: if (reload) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == StPack) || (r_state == StPad)) begin
            r_blk[r_fill[5:2]] <= r_blk[r_fill[5:2]] & ~(32'hff000000 >> {r_fill[1:0], 3'b000})
                                | ({pbyte, 24'h0} >> {r_fill[1:0], 3'b000});
        end
        if (s_in.valid && s_in.ready) begin
            r_word <= s_in.message_word;
            r_cnt  <= cnt_sat;
            r_last <= s_in.last;
        end else if (r_state == StPack) begin
            r_word <= {r_word[23:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_fill   <= '0;
            r_len    <= '0;
            r_bi     <= '0;
            r_padded <= 1'b0;
            r_lenok  <= 1'b0;
            r_lenin  <= 1'b0;
            r_resume <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in.valid && s_in.ready) begin
                r_len <= r_len + 61'(cnt_sat);
                r_bi  <= '0;
            end
            if ((r_state == StPack) || (r_state == StPad)) begin
                r_fill <= r_fill + 6'd1;
                if (r_state == StPack) begin
                    r_bi <= r_bi + 2'd1;
                    if (r_fill == 6'd63 && !pack_end) r_resume <= 1'b1;
                end
                if (r_state == StPad) begin
                    r_padded <= 1'b1;
                    if (!r_padded && r_fill < LenStart) r_lenok <= 1'b1;
                    if (r_lenok && r_fill == 6'd63) r_lenin <= 1'b1;
                end
            end
            if (r_state == StWait && stat.done) begin
                r_resume <= 1'b0;
                if (r_padded) r_lenok <= 1'b1;
            end
            if (r_state == StWait && n_state == StOut) begin
                r_ovalid <= 1'b1;
                r_oidx   <= '0;
            end
            if (r_state == StOut && m_out.ready && r_ovalid) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_ovalid <= 1'b0;
                    r_len    <= '0;
                    r_padded <= 1'b0;
                    r_lenok  <= 1'b0;
                    r_lenin  <= 1'b0;
                end
            end
        end
    end

    assign m_out.valid       = r_ovalid;
    assign m_out.digest_word = cv[r_oidx];
    assign m_out.word_index  = r_oidx;
    assign m_out.last_word   = (r_oidx == 3'd7);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> !m_out.valid) else $error("input ready while digest pending");
    a_fill_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_fill == 6'd0) else $error("fill count not cleared after block");
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.ready && m_out.last_word) |=> !m_out.valid)
        else $error("output continued past last word");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !stat.busy) else $error("block launched while round unit busy");
endmodule

@@ verif/sm3_tb_if.sv @@
// Testbench-side note: the stream interfaces come from rtl/sm3_if.sv.
// This file holds a small shared package of testbench limits; depends on nothing.
package sm3_tb_pkg;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned BlockBytes  = 64;
endpackage

@@ verif/testbench.sv @@
// Self-checking testbench for the SM3 hash engine: directed table, then random messages.
// Depends on sm3_pkg, sm3_if, sm3_hash_engine (rtl) and sm3_tb_pkg; digests are predicted in-bench.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sm3_pkg::*;
    import sm3_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    sm3_in_if  s_in ();
    sm3_out_if m_out ();

    sm3_hash_engine DUT (.i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_out(m_out));

    typedef struct {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } t_msg_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest_item;

    // Predictor state: a private copy of the hash engine.
    t_word       chain_q [8];
    t_word       block_q [16];
    int unsigned fill_q;
    logic [60:0] length_q;

    t_digest_item digest_queue [$];
    t_msg_item    stim_queue [$];
    int unsigned  error_count = 0;
    int unsigned  digest_count = 0;
    int unsigned  sent_count = 0;
    bit           stim_done = 0;
    bit           hold_sink = 0;

    function automatic t_word rot_left(t_word x, int unsigned n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word perm_zero(t_word x);
        return x ^ rot_left(x, 9) ^ rot_left(x, 17);
    endfunction

    function automatic t_word perm_one(t_word x);
        return x ^ rot_left(x, 15) ^ rot_left(x, 23);
    endfunction

    task automatic compress_block_model();
        t_word w [68];
        t_word r [8];
        t_word tj, a12, ss1, ss2, f1, g1, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = block_q[j];
        for (int j = 16; j < 68; j++)
            w[j] = perm_one(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
                   ^ rot_left(w[j-13], 7) ^ w[j-6];
        for (int j = 0; j < 8; j++) r[j] = chain_q[j];
        for (int k = 0; k < 64; k++) begin
            tj  = (k < 16) ? TjLow : TjHigh;
            a12 = rot_left(r[0], 12);
            ss1 = rot_left(a12 + r[4] + rot_left(tj, k), 7);
            ss2 = ss1 ^ a12;
            f1  = (k < 16) ? (r[0] ^ r[1] ^ r[2])
                           : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
            g1  = (k < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
            tt1 = f1 + r[3] + ss2 + (w[k] ^ w[k+4]);
            tt2 = g1 + r[7] + ss1 + w[k];
            r[3] = r[2]; r[2] = rot_left(r[1], 9); r[1] = r[0]; r[0] = tt1;
            r[7] = r[6]; r[6] = rot_left(r[5], 19); r[5] = r[4]; r[4] = perm_zero(tt2);
        end
        for (int j = 0; j < 8; j++) chain_q[j] ^= r[j];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        int unsigned sh;
        sh = 24 - 8 * (fill_q % 4);
        block_q[fill_q / 4] = (block_q[fill_q / 4] & ~(32'hFF << sh)) | (t_word'(b) << sh);
        fill_q++;
        if (fill_q == BlockBytes) begin
            compress_block_model();
            fill_q = 0;
        end
    endtask

    task automatic reload_iv();
        for (int j = 0; j < 8; j++) chain_q[j] = iv_word(3'(j));
        fill_q = 0;
        length_q = '0;
    endtask

    // Applies one accepted transfer to the model and queues any digest words.
    task automatic hash_transfer(t_msg_item it);
        int unsigned n;
        logic [63:0] bits;
        n = (it.cnt > 4) ? 4 : it.cnt;
        length_q += 61'(n);
        for (int i = 0; i < n; i++) absorb_byte(it.word[31 - 8*i -: 8]);
        if (it.last) begin
            bits = {length_q, 3'b000};
            absorb_byte(PadByte);
            while (fill_q != LenStart) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(bits[63 - 8*i -: 8]);
            for (int i = 0; i < DigestWords; i++)
                digest_queue.push_back('{chain_q[i], 3'(i), i == 7});
            reload_iv();
        end
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("sm3_hash_engine verification failed");
        $finish;
    end

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Builds the directed rows, then random messages with random bytes.
    task automatic build_stimulus();
        int unsigned len;
        logic [2:0] c;
        // Empty message; its digest is the well-known value starting 1ab21d83.
        stim_queue.push_back('{32'h0, 3'd0, 1'b1});
        // The standard "abc" vector, then one with an oversize count and a zero-count skip.
        stim_queue.push_back('{32'h61626300, 3'd3, 1'b1});
        stim_queue.push_back('{32'hFFFFFFFF, 3'd0, 1'b0});
        stim_queue.push_back('{32'hFFFFFFFF, 3'd7, 1'b0});
        stim_queue.push_back('{32'h00000000, 3'd5, 1'b0});
        stim_queue.push_back('{32'hA5A5A5A5, 3'd6, 1'b1});
        // Exactly 56 bytes, forcing a second padding block.
        for (int i = 0; i < 14; i++) stim_queue.push_back('{32'h61626364, 3'd4, i == 13});
        stim_queue.push_back('{32'h12345678, 3'd1, 1'b0});
        stim_queue.push_back('{32'h9ABCDEF0, 3'd2, 1'b1});
        while (stim_queue.size() < 255) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                c = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                stim_queue.push_back('{$urandom, c, i == len - 1});
            end
        end
    endtask

    // Source side: presents items at the falling edge and holds until the transfer.
    initial begin
        t_msg_item it;
        int unsigned gap;
        s_in.valid = 0; s_in.message_word = '0; s_in.byte_count = '0; s_in.last = 0;
        i_rst_n = 0;
        reload_iv();
        for (int j = 0; j < 16; j++) block_q[j] = '0;
        build_stimulus();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        while (stim_queue.size() > 0) begin
            it = stim_queue.pop_front();
            s_in.valid = 1; s_in.message_word = it.word;
            s_in.byte_count = it.cnt; s_in.last = it.last;
            do @(posedge i_clk); while (!s_in.ready);
            hash_transfer(it);
            sent_count++;
            @(negedge i_clk);
            gap = gap_len();
            if (sent_count % 60 == 0) gap = 0;
            if (gap > 0 || stim_queue.size() == 0) begin
                s_in.valid = 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        stim_done = 1;
    end

    // Sink side: random ready, with one long hold-off once the source has sent over 120 transfers.
    initial begin
        int unsigned stall;
        m_out.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sent_count > 120 && sent_count < 130 && !hold_sink) begin
                hold_sink = 1;
                m_out.ready = 0;
                for (int i = 0; i < 3000; i++) @(negedge i_clk);
            end
            stall = gap_len();
            if (stall > 0 && $urandom_range(0, 1) == 0) begin
                m_out.ready = 0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_out.ready = 1;
            end
        end
    end

    // Monitor: compares each digest transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_item exp_item;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, m_out.digest_word);
                error_count++;
            end else begin
                exp_item = digest_queue.pop_front();
                if (m_out.digest_word !== exp_item.word || m_out.word_index !== exp_item.idx ||
                    m_out.last_word !== exp_item.fin) begin
                    $display("%0t: expected word %h idx %0d last %b, got %h idx %0d last %b",
                             $time, exp_item.word, exp_item.idx, exp_item.fin,
                             m_out.digest_word, m_out.word_index, m_out.last_word);
                    error_count++;
                end
                digest_count++;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d message transfers and checked %0d digest words,", sent_count,
                 digest_count);
        $display("including padding across block edges and a long output stall.");
        if (error_count == 0) begin
            $display("sm3_hash_engine verification clean");
        end else begin
            $display("sm3_hash_engine verification failed");
        end
        $finish;
    end
endmodule
